// ----- rtl/ots_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ots_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ots_pkg;
    localparam int LEVELS_DEF     = 256;
    localparam int COUNT_BITS_DEF = 22;

    typedef struct packed {
        logic bin_en;    // bin an incoming item
        logic sw_start;  // load sweep accumulators
        logic rd_issue;  // read histogram at sweep index
        logic step;      // use read data for one level
        logic mul_go;    // advance multiply sequence
        logic clr_start; // begin clearing pass
        logic clr_en;    // clear at sweep index
        logic finish;    // reset frame totals
    } ots_cmd_t;

    typedef struct packed {
        logic idx_last;  // sweep index at LEVELS-1
        logic stop;      // foreground became empty
        logic mul_done;  // multiply sequence finished
        logic skip;      // background still empty at this level
    } ots_sts_t;
endpackage
`default_nettype wire

// ----- rtl/ots_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ots_mul
// Shift-add multiplier, one bit of b per cycle.
// ----------------------------------------------------------------------------
module ots_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [AW-1:0]      a,
    input  wire logic [BW-1:0]      b,
    output logic                    done,
    output logic [AW+BW-1:0]        prod
);
    localparam int CW = $clog2(BW + 1);
    logic [AW+BW-1:0] acc_reg, sa_reg;
    logic [BW-1:0]    sb_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(BW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            sa_reg  <= (AW+BW)'(a);
            sb_reg  <= b;
        end
        else if (busy_reg)
        begin
            if (sb_reg[0])
                acc_reg <= acc_reg + sa_reg;
            sa_reg <= sa_reg << 1;
            sb_reg <= sb_reg >> 1;
        end
    end

    assign done = !busy_reg && !start;
    assign prod = acc_reg;
endmodule
`default_nettype wire

// ----- rtl/ots_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ots_datapath
// Histogram memory, frame totals and the exact variance compare.
// ----------------------------------------------------------------------------
module ots_datapath #(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 22
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [7:0]      pixel,
    input  ots_pkg::ots_cmd_t    cmd,
    output ots_pkg::ots_sts_t    sts,
    output logic [7:0]           threshold
);
    import ots_pkg::*;
    localparam int IW = $clog2(LEVELS);
    localparam int CB = COUNT_BITS;
    localparam int SW = CB + IW;          // weighted sums
    localparam int PW = SW + CB;          // sB*N
    localparam int DW = 2 * PW;           // D^2
    localparam int QW = 2 * CB;           // wB*wF
    localparam int XW = DW + QW;          // cross products

    logic [CB-1:0] hist [LEVELS];
    logic [CB-1:0] rd_reg;
    logic [CB-1:0] rdb_reg, wdat;
    logic [IW-1:0] pa_reg;
    logic          va_reg;
    logic [CB-1:0] cnt_reg, wb_reg, wbn;
    logic [SW-1:0] sum_reg, sb_reg;
    logic [IW-1:0] idx_reg;
    logic [DW-1:0] bnum_reg;
    logic [QW-1:0] bden_reg;
    logic [IW-1:0] best_reg;
    logic [2:0]    ph_reg;
    logic [PW-1:0] p1_reg, dd;
    logic [DW-1:0] d2_reg;
    logic [QW-1:0] q_reg;
    logic          fits;
    logic          pend_reg;

    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    assign fits = (LEVELS >= 256) || ({1'b0, pixel} < 9'(LEVELS));

    // binning reads, then writes in the following cycle; back-to-back hits on the
    // same bin and a sweep read right after the last pixel take the bypass
    assign wdat = rdb_reg + CB'(1);

    // histogram memory: one port for binning/clearing writes, two reads
    always_ff @(posedge clk)
    begin
        if (cmd.clr_en)
            hist[idx_reg] <= '0;
        else if (va_reg)
            hist[pa_reg] <= wdat;
        if (cmd.bin_en)
            rdb_reg <= (va_reg && pa_reg == IW'(pixel)) ? wdat : hist[IW'(pixel)];
        if (cmd.rd_issue)
            rd_reg <= (va_reg && pa_reg == idx_reg) ? wdat : hist[idx_reg];
    end

    assign wbn = wb_reg + rd_reg;

    // shared multiplier, operands sequenced by phase
    logic          m_start;
    logic [DW-1:0] m_a;
    logic [XW-1:0] m_b;
    logic [DW+XW-1:0] m_p;
    logic          m_done;

    always_comb
    begin
        unique case (ph_reg)
            3'd0:    begin m_a = DW'(sb_reg);  m_b = XW'(cnt_reg); end
            3'd1:    begin m_a = DW'(sum_reg); m_b = XW'(wb_reg);  end
            3'd2:    begin m_a = DW'(dd);      m_b = XW'(dd);      end
            3'd3:    begin m_a = DW'(wb_reg);  m_b = XW'(cnt_reg - wb_reg); end
            3'd4:    begin m_a = d2_reg;       m_b = XW'(bden_reg); end
            default: begin m_a = bnum_reg;     m_b = XW'(q_reg);   end
        endcase
    end
    assign m_start = pend_reg;

    ots_mul #(.AW(DW), .BW(XW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start),
        .a(m_a), .b(m_b), .done(m_done), .prod(m_p)
    );

    logic [XW-1:0] lhs_reg;
    logic          mwait_reg;
    // phase 1 result is used combinationally for dd in phase 2 launch
    assign dd = (p1_reg >= PW'(m_p)) ? p1_reg - PW'(m_p) : PW'(m_p) - p1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            sum_reg   <= '0;
            idx_reg   <= '0;
            ph_reg    <= '0;
            mwait_reg <= 1'b0;
            pend_reg  <= 1'b0;
            va_reg    <= 1'b0;
            pa_reg    <= '0;
            best_reg  <= '0;
            wb_reg    <= '0;
            sb_reg    <= '0;
            bnum_reg  <= '0;
            bden_reg  <= QW'(1);
            p1_reg    <= '0;
            d2_reg    <= '0;
            q_reg     <= '0;
            lhs_reg   <= '0;
        end
        else
        begin
            va_reg <= cmd.bin_en && cnt_reg != CMAX && fits;
            pa_reg <= IW'(pixel);
            if (cmd.bin_en && cnt_reg != CMAX)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (fits)
                    sum_reg <= sum_reg + SW'(pixel);
            end
            if (cmd.sw_start || cmd.clr_start)
                idx_reg <= '0;
            else if ((cmd.step && sts.skip) || cmd.clr_en)
                idx_reg <= idx_reg + 1'b1;
            if (cmd.sw_start)
            begin
                best_reg <= '0;
                wb_reg   <= '0;
                sb_reg   <= '0;
                bnum_reg <= '0;
                bden_reg <= QW'(1);
            end
            if (cmd.step)
            begin
                wb_reg <= wbn;
                ph_reg <= '0;
                if (!sts.skip)
                    sb_reg <= sb_reg + SW'(idx_reg) * SW'(rd_reg);
            end
            // each phase launches in the cycle after its request, so the first
            // one sees the sums updated by the step
            if (cmd.mul_go)
                pend_reg <= 1'b1;
            else if (pend_reg)
            begin
                pend_reg  <= 1'b0;
                mwait_reg <= 1'b1;
            end
            else if (mwait_reg && m_done)
            begin
                mwait_reg <= 1'b0;
                unique case (ph_reg)
                    3'd0: p1_reg <= PW'(m_p);
                    3'd1: ;
                    3'd2: d2_reg <= DW'(m_p);
                    3'd3: q_reg <= QW'(m_p);
                    3'd4: lhs_reg <= XW'(m_p);
                    default:
                    begin
                        if (lhs_reg > XW'(m_p))
                        begin
                            bnum_reg <= d2_reg;
                            bden_reg <= q_reg;
                            best_reg <= idx_reg;
                        end
                    end
                endcase
                if (ph_reg == 3'd5)
                    idx_reg <= idx_reg + 1'b1;
                else
                    pend_reg <= 1'b1;
                ph_reg <= (ph_reg == 3'd5) ? 3'd0 : ph_reg + 1'b1;
            end
            if (cmd.finish)
            begin
                cnt_reg <= '0;
                sum_reg <= '0;
            end
        end
    end

    assign sts.idx_last = (idx_reg == IW'(LEVELS - 1));
    assign sts.skip     = (wbn == '0);
    assign sts.stop     = (wbn >= cnt_reg);
    assign sts.mul_done = !mwait_reg && !pend_reg && !cmd.mul_go && (ph_reg == 3'd0);
    assign threshold    = 8'(best_reg);
endmodule
`default_nettype wire

// ----- rtl/otsu_threshold.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otsu_threshold
// Streaming Otsu threshold over an 8-bit grey histogram.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one pixel per item, last_pixel marks the
// end of a frame. Pixels that are not last are taken one per cycle outside a
// sweep or clearing pass. On a last pixel the block stalls input and sweeps
// the histogram: a level with an empty background passes only the read and
// step states; a level with both classes occupied runs six multiplications
// on a shared shift-add unit, one after another. The sweep stops at the first
// level that empties the foreground. Then a clearing pass empties the
// histogram and one threshold item is offered on out_valid/out_stall after
// that pass. It is held while out_stall is high; pixels of the next frame are
// taken meanwhile, but its last pixel waits until the output register frees.
// Reset clears the totals and runs a clearing pass before the first pixel is
// accepted.
// ----------------------------------------------------------------------------
module otsu_threshold #(
    parameter int LEVELS     = ots_pkg::LEVELS_DEF,
    parameter int COUNT_BITS = ots_pkg::COUNT_BITS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] pixel,
    input  wire logic       last_pixel,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      threshold
);
    import ots_pkg::*;
    ots_cmd_t cmd;
    ots_sts_t sts;
    logic [7:0] thr_w;

    ots_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .last_pixel(last_pixel),
        .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
        .thr_in(thr_w), .threshold(threshold), .cmd(cmd), .sts(sts)
    );

    ots_datapath #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .pixel(pixel), .cmd(cmd), .sts(sts),
        .threshold(thr_w)
    );

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(threshold))
        else $error("result dropped under stall");
    a_nobin: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> !cmd.bin_en)
        else $error("binning while stalled");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_en && cmd.bin_en))
        else $error("clear and bin together");
endmodule
`default_nettype wire

// ----- rtl/ots_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ots_ctrl
// Frame sequencer: accept, sweep, clear, deliver.
// ----------------------------------------------------------------------------
module ots_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          last_pixel,
    output logic               in_stall,
    output logic               out_valid,
    input  wire logic          out_stall,
    input  wire logic [7:0]    thr_in,
    output logic [7:0]         threshold,
    output ots_pkg::ots_cmd_t  cmd,
    input  ots_pkg::ots_sts_t  sts
);
    import ots_pkg::*;
    typedef enum logic [2:0] {S_CLR, S_RUN, S_RD, S_STEP, S_MUL, S_OUT} state_t;
    state_t state_reg;
    logic   ov_reg, last_reg, lvl_last_reg;
    logic [7:0] thr_reg;
    logic   acc;

    // only a last pixel has to wait for the output register
    assign in_stall  = (state_reg != S_RUN) || (ov_reg && last_pixel);
    assign acc       = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign threshold = thr_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.bin_en    = acc;
        cmd.sw_start  = acc && last_pixel;
        cmd.rd_issue  = (state_reg == S_RD);
        cmd.step      = (state_reg == S_STEP) && !sts.stop;
        cmd.mul_go    = (state_reg == S_STEP) && !sts.stop && !sts.skip;
        cmd.clr_start = ((state_reg == S_STEP) &&
                         (sts.stop || (sts.skip && sts.idx_last))) ||
                        (state_reg == S_OUT);
        cmd.clr_en    = (state_reg == S_CLR);
        cmd.finish    = cmd.clr_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            ov_reg       <= 1'b0;
            last_reg     <= 1'b0;
            lvl_last_reg <= 1'b0;
            thr_reg      <= '0;
        end
        else
        begin
            if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_RUN:  if (acc && last_pixel) state_reg <= S_RD;
                S_RD:   state_reg <= S_STEP;
                S_STEP:
                begin
                    if (cmd.clr_start)
                    begin
                        state_reg <= S_CLR;
                        last_reg  <= 1'b1;
                    end
                    else if (sts.skip)
                        state_reg <= S_RD;
                    else
                    begin
                        state_reg    <= S_MUL;
                        lvl_last_reg <= sts.idx_last;
                    end
                end
                S_MUL:
                    if (sts.mul_done)
                        state_reg <= lvl_last_reg ? S_OUT : S_RD;
                S_OUT:
                begin
                    state_reg <= S_CLR;
                    last_reg  <= 1'b1;
                end
                S_CLR:
                    if (sts.idx_last)
                    begin
                        state_reg <= S_RUN;
                        if (last_reg)
                        begin
                            ov_reg   <= 1'b1;
                            thr_reg  <= thr_in;
                            last_reg <= 1'b0;
                        end
                    end
                default: state_reg <= S_CLR;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/sv/otsu_threshold_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// otsu_threshold_tb
// Streams grey frames into the block and checks each emitted threshold
// against an in-bench Otsu predictor using exact integer variance compares.
// Both sides idle and stall in random bursts.
// ----------------------------------------------------------------------------
module otsu_threshold_tb;
    import ots_pkg::*;

    localparam int NLEV = LEVELS_DEF;
    localparam int CBITS = COUNT_BITS_DEF;
    localparam int N_ITEMS = 1850;

    typedef struct {
        logic [7:0] pix;
        logic       last;
        logic       drain;   // hold until all thresholds are back
    } pix_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] pixel = 8'd0;
    logic       last_pixel = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] threshold;

    pix_item_t  pix_q[$];
    logic [7:0] thr_q[$];
    int         errors = 0;
    int         sent = 0;
    int         in_gap = 0;
    int         out_gap = 0;
    bit         quiet = 1'b0;

    // predictor state
    logic [CBITS-1:0]   hist[NLEV];
    logic [CBITS-1:0]   tot_cnt = '0;
    logic [CBITS+7:0]   tot_sum = '0;

    otsu_threshold DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel(pixel), .last_pixel(last_pixel),
        .out_valid(out_valid), .out_stall(out_stall),
        .threshold(threshold)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] otsu_level();
        logic [255:0] wb, sb, wf, p1, p2, d, d2, den;
        logic [255:0] best_num, best_den, lhs, rhs;
        logic [7:0]   best_t;
        best_num = '0;
        best_den = 256'd1;
        best_t = '0;
        wb = '0;
        sb = '0;
        for (int t = 0; t < NLEV; t++)
        begin
            wb += hist[t];
            if (wb == 0)
                continue;
            if (wb >= tot_cnt)
                break;
            wf = tot_cnt - wb;
            sb += t * hist[t];
            p1 = sb * tot_cnt;
            p2 = tot_sum * wb;
            d = (p1 >= p2) ? p1 - p2 : p2 - p1;
            d2 = d * d;
            den = wb * wf;
            lhs = d2 * best_den;
            rhs = best_num * den;
            if (lhs > rhs)
            begin
                best_num = d2;
                best_den = den;
                best_t = t[7:0];
            end
        end
        return best_t;
    endfunction

    task automatic take_pixel(input logic [7:0] p, input logic lst);
        if (tot_cnt != {CBITS{1'b1}})
        begin
            tot_cnt++;
            if (p < NLEV)
            begin
                hist[p]++;
                tot_sum += p;
            end
        end
        if (lst)
        begin
            thr_q.push_back(otsu_level());
            foreach (hist[i]) hist[i] = '0;
            tot_cnt = '0;
            tot_sum = '0;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                take_pixel(pixel, last_pixel);
                sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (!quiet && $urandom_range(0, 9) == 0)
                begin
                    in_gap <= $urandom_range(0, 11);
                    in_valid <= 1'b0;
                end
                else if (pix_q.size() > 0 &&
                         !(pix_q[0].drain && (thr_q.size() > 0 ||
                           (in_valid && !in_stall && last_pixel))))
                begin
                    pixel <= pix_q[0].pix;
                    last_pixel <= pix_q[0].last;
                    in_valid <= 1'b1;
                    void'(pix_q.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
            if (sent > N_ITEMS * 9 / 10)
                quiet <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (thr_q.size() == 0)
                begin
                    $error("threshold: unexpected item, actual %0d", threshold);
                    errors++;
                end
                else
                begin
                    if (threshold !== thr_q[0])
                    begin
                        $error("threshold: expected %0d actual %0d", thr_q[0], threshold);
                        errors++;
                    end
                    void'(thr_q.pop_front());
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(0, 11);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic add_pix(input logic [7:0] p, input logic lst, input logic drn = 1'b0);
        pix_item_t it;
        it.pix = p;
        it.last = lst;
        it.drain = drn;
        pix_q.push_back(it);
    endtask

    initial
    begin
        int n, len, base, span;
        foreach (hist[i]) hist[i] = '0;

        // directed: single pixel, flat frames, extremes, a tie, every bit
        add_pix(8'd0, 1'b1);
        add_pix(8'd255, 1'b1);
        add_pix(8'd7, 1'b0);
        add_pix(8'd7, 1'b0);
        add_pix(8'd7, 1'b1);
        add_pix(8'd0, 1'b0);
        add_pix(8'd255, 1'b1);
        add_pix(8'd10, 1'b0, 1'b1);
        add_pix(8'd20, 1'b0);
        add_pix(8'd10, 1'b0);
        add_pix(8'd20, 1'b1);
        for (int b = 0; b < 8; b++)
            add_pix(8'd1 << b, b == 7);
        add_pix(8'hAA, 1'b0);
        add_pix(8'h55, 1'b1);
        n = pix_q.size();

        // random frames: mostly narrow level spread to keep sweeps short
        while (n < N_ITEMS)
        begin
            len = $urandom_range(1, 40);
            base = $urandom_range(0, 255);
            span = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 16);
            for (int k = 0; k < len; k++)
            begin
                int p;
                p = base + $urandom_range(0, span);
                if (p > 255)
                    p = 255 - $urandom_range(0, span);
                if (p < 0)
                    p = 0;
                add_pix(p[7:0], k == len - 1, k == 0 && n > N_ITEMS / 2 &&
                        n < N_ITEMS / 2 + 40);
                n++;
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pix_q.size() > 0 || in_valid || thr_q.size() > 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("status: fail");
        $finish;
    end
endmodule
